// ----- rtl/yuyv2rgb_pkg.sv -----
// Shared types, constants and arithmetic helpers for the YUYV to RGB converter.
// No dependencies; used by every module in rtl/.
package yuyv2rgb_pkg;

    localparam int PIX_W   = 8;   // byte lanes
    localparam int COEF_W  = 11;  // signed Q8 coefficients
    localparam int LUMA_W  = 10;  // Y - 16, signed
    localparam int CHROMA_W = 9;  // U/V - 128, signed
    localparam int SUM_W   = 22;  // widest channel sum plus headroom
    localparam int FRAC_W  = 8;   // Q8 fraction bits
    localparam int CFG_IDX_W = 3;

    localparam logic [LUMA_W-1:0]   LUMA_OFFSET   = LUMA_W'(16);
    localparam logic [CHROMA_W-1:0] CHROMA_OFFSET = CHROMA_W'(128);

    localparam logic signed [COEF_W-1:0] LUMA_GAIN_RST  = COEF_W'(298);
    localparam logic signed [COEF_W-1:0] U_TO_BLUE_RST  = COEF_W'(517);
    localparam logic signed [COEF_W-1:0] U_TO_GREEN_RST = -COEF_W'(97);
    localparam logic signed [COEF_W-1:0] V_TO_GREEN_RST = COEF_W'(208);
    localparam logic signed [COEF_W-1:0] V_TO_RED_RST   = COEF_W'(297);

    // Register map indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LUMA_GAIN  = 3'd0,
        CFG_U_TO_BLUE  = 3'd1,
        CFG_U_TO_GREEN = 3'd2,
        CFG_V_TO_GREEN = 3'd3,
        CFG_V_TO_RED   = 3'd4
    } t_cfg_idx;

    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic signed [SUM_W-1:0]  t_sum;

    typedef struct packed {
        t_coef luma_gain;
        t_coef u_to_blue;
        t_coef u_to_green;
        t_coef v_to_green;
        t_coef v_to_red;
    } t_coef_set;

    typedef struct packed {
        logic [PIX_W-1:0] y_first;
        logic [PIX_W-1:0] u_shared;
        logic [PIX_W-1:0] y_second;
        logic [PIX_W-1:0] v_shared;
        logic             last;
    } t_macropixel;

    typedef struct packed {
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
    } t_rgb;

    // coef * operand, both sign-extended to the sum width (product fits)
    function automatic t_sum mul_ext(input t_coef coef, input logic signed [LUMA_W-1:0] val);
        t_sum a;
        t_sum b;
        a = SUM_W'(coef);
        b = SUM_W'(val);
        return a * b;
    endfunction

    // floor shift by the Q8 fraction, clamp to a byte
    function automatic logic [PIX_W-1:0] sat_q8(input t_sum sum);
        logic [PIX_W-1:0] res;
        if (sum[SUM_W-1]) begin
            res = '0;
        end else if (|sum[SUM_W-2:FRAC_W+PIX_W]) begin
            res = '1;
        end else begin
            res = sum[FRAC_W+PIX_W-1:FRAC_W];
        end
        return res;
    endfunction

endpackage

// ----- rtl/yuyv_to_rgb_converter_core.sv -----
// YUYV 4:2:2 macropixel to two BGR pixels, programmable signed Q8 weights.
// Pipeline: input register, then the result register that drives the result strobe o_valid.
// Throughput: one macropixel per clock; busy is tied low, no stalls from either side.
// Reset (i_rst_n low, synchronous): coefficients return to defaults, in-flight beats dropped.
// The receiver cannot stall: every beat is shown for exactly one cycle.
// Depends on yuyv2rgb_pkg, yuyv2rgb_cfg_regs, yuyv2rgb_convert.
module yuyv_to_rgb_converter_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // command side
    input  logic                                start,
    output logic                                busy,
    input  logic [yuyv2rgb_pkg::PIX_W-1:0]      i_y_first,
    input  logic [yuyv2rgb_pkg::PIX_W-1:0]      i_u_shared,
    input  logic [yuyv2rgb_pkg::PIX_W-1:0]      i_y_second,
    input  logic [yuyv2rgb_pkg::PIX_W-1:0]      i_v_shared,
    input  logic                                i_last_in,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [yuyv2rgb_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [yuyv2rgb_pkg::COEF_W-1:0]     i_cfg_data,
    // result side
    output logic                                o_valid,
    output logic [yuyv2rgb_pkg::PIX_W-1:0]      o_blue_first,
    output logic [yuyv2rgb_pkg::PIX_W-1:0]      o_green_first,
    output logic [yuyv2rgb_pkg::PIX_W-1:0]      o_red_first,
    output logic [yuyv2rgb_pkg::PIX_W-1:0]      o_blue_second,
    output logic [yuyv2rgb_pkg::PIX_W-1:0]      o_green_second,
    output logic [yuyv2rgb_pkg::PIX_W-1:0]      o_red_second,
    output logic                                o_last_out
);

    yuyv2rgb_pkg::t_coef_set    coefs;
    yuyv2rgb_pkg::t_rgb         first_px;
    yuyv2rgb_pkg::t_rgb         second_px;

    // input register stage
    logic                       r_in_valid;
    yuyv2rgb_pkg::t_macropixel  r_in_pix;
    yuyv2rgb_pkg::t_macropixel  n_in_pix;
    logic                       accept;

    // The pipeline never stalls, so a beat can be taken every clock.
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    always_comb begin
        n_in_pix.y_first  = i_y_first;
        n_in_pix.u_shared = i_u_shared;
        n_in_pix.y_second = i_y_second;
        n_in_pix.v_shared = i_v_shared;
        n_in_pix.last     = i_last_in;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= accept;
        end
    end

    // payload only loads on an accepted beat
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_pix <= n_in_pix;
        end
    end

    yuyv2rgb_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_coefs    (coefs)
    );

    // multiply, sum, floor-shift and clamp, then the result register
    yuyv2rgb_convert u_convert (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_in_valid),
        .i_pix    (r_in_pix),
        .i_coefs  (coefs),
        .o_valid  (o_valid),
        .o_first  (first_px),
        .o_second (second_px),
        .o_last   (o_last_out)
    );

    assign o_blue_first   = first_px.blue;
    assign o_green_first  = first_px.green;
    assign o_red_first    = first_px.red;
    assign o_blue_second  = second_px.blue;
    assign o_green_second = second_px.green;
    assign o_red_second   = second_px.red;

endmodule

// ----- rtl/yuyv2rgb_cfg_regs.sv -----
// Coefficient register file: five signed Q8 weights with write port.
// Depends on yuyv2rgb_pkg.
module yuyv2rgb_cfg_regs (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [yuyv2rgb_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [yuyv2rgb_pkg::COEF_W-1:0]       i_cfg_data,
    output yuyv2rgb_pkg::t_coef_set               o_coefs
);

    yuyv2rgb_pkg::t_coef_set r_coefs;
    yuyv2rgb_pkg::t_coef_set n_coefs;

    always_comb begin
        n_coefs = r_coefs;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                yuyv2rgb_pkg::CFG_LUMA_GAIN:  n_coefs.luma_gain  = i_cfg_data;
                yuyv2rgb_pkg::CFG_U_TO_BLUE:  n_coefs.u_to_blue  = i_cfg_data;
                yuyv2rgb_pkg::CFG_U_TO_GREEN: n_coefs.u_to_green = i_cfg_data;
                yuyv2rgb_pkg::CFG_V_TO_GREEN: n_coefs.v_to_green = i_cfg_data;
                yuyv2rgb_pkg::CFG_V_TO_RED:   n_coefs.v_to_red   = i_cfg_data;
                default: ; // unmapped index, dropped
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs.luma_gain  <= yuyv2rgb_pkg::LUMA_GAIN_RST;
            r_coefs.u_to_blue  <= yuyv2rgb_pkg::U_TO_BLUE_RST;
            r_coefs.u_to_green <= yuyv2rgb_pkg::U_TO_GREEN_RST;
            r_coefs.v_to_green <= yuyv2rgb_pkg::V_TO_GREEN_RST;
            r_coefs.v_to_red   <= yuyv2rgb_pkg::V_TO_RED_RST;
        end else begin
            r_coefs <= n_coefs;
        end
    end

    assign o_coefs = r_coefs;

endmodule

// ----- rtl/yuyv2rgb_convert.sv -----
// Color math for one macropixel: products, channel sums, saturation, result register.
// Depends on yuyv2rgb_pkg.
module yuyv2rgb_convert (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  yuyv2rgb_pkg::t_macropixel   i_pix,
    input  yuyv2rgb_pkg::t_coef_set     i_coefs,
    output logic                        o_valid,
    output yuyv2rgb_pkg::t_rgb          o_first,
    output yuyv2rgb_pkg::t_rgb          o_second,
    output logic                        o_last
);

    localparam int LW = yuyv2rgb_pkg::LUMA_W;
    localparam int CW = yuyv2rgb_pkg::CHROMA_W;

    logic signed [LW-1:0] y0;
    logic signed [LW-1:0] y1;
    logic signed [CW-1:0] u;
    logic signed [CW-1:0] v;

    yuyv2rgb_pkg::t_sum l0, l1, cb, cg, cr;
    yuyv2rgb_pkg::t_rgb n_first, n_second;

    logic                r_valid;
    yuyv2rgb_pkg::t_rgb  r_first, r_second;
    logic                r_last;

    always_comb begin
        y0 = signed'(LW'(i_pix.y_first)  - yuyv2rgb_pkg::LUMA_OFFSET);
        y1 = signed'(LW'(i_pix.y_second) - yuyv2rgb_pkg::LUMA_OFFSET);
        u  = signed'(CW'(i_pix.u_shared) - yuyv2rgb_pkg::CHROMA_OFFSET);
        v  = signed'(CW'(i_pix.v_shared) - yuyv2rgb_pkg::CHROMA_OFFSET);

        // chroma terms are shared by both pixels
        l0 = yuyv2rgb_pkg::mul_ext(i_coefs.luma_gain, y0);
        l1 = yuyv2rgb_pkg::mul_ext(i_coefs.luma_gain, y1);
        cb = yuyv2rgb_pkg::mul_ext(i_coefs.u_to_blue, LW'(u));
        cr = yuyv2rgb_pkg::mul_ext(i_coefs.v_to_red, LW'(v));
        cg = yuyv2rgb_pkg::mul_ext(i_coefs.u_to_green, LW'(u))
           + yuyv2rgb_pkg::mul_ext(i_coefs.v_to_green, LW'(v));

        n_first.blue   = yuyv2rgb_pkg::sat_q8(l0 + cb);
        n_first.green  = yuyv2rgb_pkg::sat_q8(l0 + cg);
        n_first.red    = yuyv2rgb_pkg::sat_q8(l0 + cr);
        n_second.blue  = yuyv2rgb_pkg::sat_q8(l1 + cb);
        n_second.green = yuyv2rgb_pkg::sat_q8(l1 + cg);
        n_second.red   = yuyv2rgb_pkg::sat_q8(l1 + cr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_first  <= n_first;
            r_second <= n_second;
            r_last   <= i_pix.last;
        end
    end

    assign o_valid  = r_valid;
    assign o_first  = r_first;
    assign o_second = r_second;
    assign o_last   = r_last;

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking bench for yuyv_to_rgb_converter_core: directed table, then random beats.
// Depends on yuyv2rgb_pkg and the converter RTL; a scoreboard tracks the coefficient file.
`timescale 1ns / 100ps

module tb;
    import yuyv2rgb_pkg::*;

    // Pipeline latency of the RTL, used to let the pipe settle after a drain.
    localparam int PIPE_LATENCY   = 2;
    localparam int DRAIN_GUARD    = 1000;
    localparam int MAX_REPORTED   = 10;
    localparam int PHASE_COUNT    = 9;
    localparam int BEATS_PER_PHASE = 135;
    localparam int CFG_IDX_LAST   = (1 << CFG_IDX_W) - 1;

    // Two converted pixels plus the frame mark, in port order.
    typedef struct packed {
        t_rgb first;
        t_rgb second;
        logic last;
    } t_bgr_pair;

    // One row of the directed table; golden is only trusted when golden_en is set.
    typedef struct {
        t_macropixel mp;
        bit          golden_en;
        t_bgr_pair   golden;
    } t_stim_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic [PIX_W-1:0]     i_y_first;
    logic [PIX_W-1:0]     i_u_shared;
    logic [PIX_W-1:0]     i_y_second;
    logic [PIX_W-1:0]     i_v_shared;
    logic                 i_last_in;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [COEF_W-1:0]    i_cfg_data;
    logic                 o_valid;
    logic [PIX_W-1:0]     o_blue_first;
    logic [PIX_W-1:0]     o_green_first;
    logic [PIX_W-1:0]     o_red_first;
    logic [PIX_W-1:0]     o_blue_second;
    logic [PIX_W-1:0]     o_green_second;
    logic [PIX_W-1:0]     o_red_second;
    logic                 o_last_out;

    // Golden value riding along with the beat on the wire, sampled with it.
    logic                 beat_golden_en;
    t_bgr_pair            beat_golden;

    t_coef_set            shadow_coefs;   // bench copy of the coefficient file
    t_bgr_pair            pending_bgr[$]; // expected results, oldest first
    t_stim_row            directed_rows[$];
    int                   fail_count = 0;

    yuyv_to_rgb_converter_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_y_first      (i_y_first),
        .i_u_shared     (i_u_shared),
        .i_y_second     (i_y_second),
        .i_v_shared     (i_v_shared),
        .i_last_in      (i_last_in),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_valid        (o_valid),
        .o_blue_first   (o_blue_first),
        .o_green_first  (o_green_first),
        .o_red_first    (o_red_first),
        .o_blue_second  (o_blue_second),
        .o_green_second (o_green_second),
        .o_red_second   (o_red_second),
        .o_last_out     (o_last_out)
    );

    // 10 ns clock, first rising edge at 5 ns.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hard stop in case the handshake or the drain loop hangs.
    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic t_coef_set reset_coefs();
        t_coef_set c;
        c.luma_gain  = LUMA_GAIN_RST;
        c.u_to_blue  = U_TO_BLUE_RST;
        c.u_to_green = U_TO_GREEN_RST;
        c.v_to_green = V_TO_GREEN_RST;
        c.v_to_red   = V_TO_RED_RST;
        return c;
    endfunction

    // Arithmetic shift is a floor shift on int; then clamp to a byte.
    function automatic logic [PIX_W-1:0] clamp_q8(input int sum);
        int q;
        q = sum >>> FRAC_W;
        if (q < 0) begin
            return '0;
        end else if (q > 255) begin
            return '1;
        end
        return q[PIX_W-1:0];
    endfunction

    function automatic t_rgb convert_pixel(input t_coef_set c, input logic [PIX_W-1:0] y,
                                           input int u_off, input int v_off);
        t_rgb px;
        int   luma;
        luma     = int'(c.luma_gain) * (int'(y) - int'(LUMA_OFFSET));
        px.blue  = clamp_q8(luma + int'(c.u_to_blue) * u_off);
        px.green = clamp_q8(luma + int'(c.u_to_green) * u_off + int'(c.v_to_green) * v_off);
        px.red   = clamp_q8(luma + int'(c.v_to_red) * v_off);
        return px;
    endfunction

    function automatic t_bgr_pair convert_macropixel(input t_coef_set c, input t_macropixel mp);
        t_bgr_pair res;
        int        u_off;
        int        v_off;
        u_off      = int'(mp.u_shared) - int'(CHROMA_OFFSET);
        v_off      = int'(mp.v_shared) - int'(CHROMA_OFFSET);
        res.first  = convert_pixel(c, mp.y_first, u_off, v_off);
        res.second = convert_pixel(c, mp.y_second, u_off, v_off);
        res.last   = mp.last;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Scoreboard: everything sampled on the rising edge, inputs move on the
    // falling edge, so nothing here depends on event order in a time step.
    // Compare comes first; a beat accepted now shows up only after the input and result registers.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_bgr_pair got;
        t_bgr_pair exp_bgr;
        t_macropixel mp;
        if (!i_rst_n) begin
            shadow_coefs = reset_coefs();
            pending_bgr.delete();
        end else begin
            if (o_valid) begin
                got = {o_blue_first, o_green_first, o_red_first,
                       o_blue_second, o_green_second, o_red_second, o_last_out};
                if (pending_bgr.size() == 0) begin
                    if (fail_count < MAX_REPORTED) begin
                        $display("[%0t] unexpected result beat: %h", $realtime, got);
                    end
                    fail_count++;
                end else begin
                    exp_bgr = pending_bgr.pop_front();
                    if (got !== exp_bgr) begin
                        if (fail_count < MAX_REPORTED) begin
                            $display("[%0t] mismatch 1st bgr exp %h %h %h got %h %h %h",
                                     $realtime, exp_bgr.first.blue, exp_bgr.first.green,
                                     exp_bgr.first.red, got.first.blue, got.first.green,
                                     got.first.red);
                            $display("        2nd bgr exp %h %h %h got %h %h %h last %b/%b",
                                     exp_bgr.second.blue, exp_bgr.second.green,
                                     exp_bgr.second.red, got.second.blue, got.second.green,
                                     got.second.red, exp_bgr.last, got.last);
                        end
                        fail_count++;
                    end
                end
            end
            if (start && !busy) begin
                mp = {i_y_first, i_u_shared, i_y_second, i_v_shared, i_last_in};
                if (beat_golden_en) begin
                    pending_bgr.push_back(beat_golden);
                end else begin
                    pending_bgr.push_back(convert_macropixel(shadow_coefs, mp));
                end
            end
            // Out-of-range indexes fall through and leave the file alone.
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_LUMA_GAIN:  shadow_coefs.luma_gain  = t_coef'(i_cfg_data);
                    CFG_U_TO_BLUE:  shadow_coefs.u_to_blue  = t_coef'(i_cfg_data);
                    CFG_U_TO_GREEN: shadow_coefs.u_to_green = t_coef'(i_cfg_data);
                    CFG_V_TO_GREEN: shadow_coefs.v_to_green = t_coef'(i_cfg_data);
                    CFG_V_TO_RED:   shadow_coefs.v_to_red   = t_coef'(i_cfg_data);
                    default: ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // gold_byte applies to all six channels; only used for trivially known rows.
    function automatic void add_row(input int y0, input int u, input int y1, input int v,
                                    input bit last, input bit golden_en, input int gold_byte);
        t_stim_row row;
        row.mp.y_first    = PIX_W'(y0);
        row.mp.u_shared   = PIX_W'(u);
        row.mp.y_second   = PIX_W'(y1);
        row.mp.v_shared   = PIX_W'(v);
        row.mp.last       = last;
        row.golden_en     = golden_en;
        row.golden.first  = {PIX_W'(gold_byte), PIX_W'(gold_byte), PIX_W'(gold_byte)};
        row.golden.second = row.golden.first;
        row.golden.last   = last;
        directed_rows.push_back(row);
    endfunction

    function automatic logic [PIX_W-1:0] corner_byte();
        case ($urandom_range(7))
            0: return 8'd0;
            1: return 8'd1;
            2: return 8'd16;
            3: return 8'd127;
            4: return 8'd128;
            5: return 8'd235;
            6: return 8'd254;
            default: return 8'd255;
        endcase
    endfunction

    // Mostly uniform bytes, with corner values, grey beats and legal video range mixed in.
    function automatic t_macropixel random_macropixel();
        t_macropixel mp;
        int          mode;
        mode = $urandom_range(9);
        // 32 random bits cover the four bytes; the frame mark is drawn below
        mp   = t_macropixel'({$urandom, 1'b0});
        case (mode)
            6: begin
                mp.y_first  = corner_byte();
                mp.u_shared = corner_byte();
                mp.y_second = corner_byte();
                mp.v_shared = corner_byte();
            end
            7: begin
                mp.u_shared = CHROMA_OFFSET[PIX_W-1:0];
                mp.v_shared = CHROMA_OFFSET[PIX_W-1:0];
            end
            8: begin
                mp.y_first  = PIX_W'($urandom_range(235, 16));
                mp.y_second = PIX_W'($urandom_range(235, 16));
                mp.u_shared = PIX_W'($urandom_range(240, 16));
                mp.v_shared = PIX_W'($urandom_range(240, 16));
            end
            default: ;
        endcase
        mp.last = ($urandom_range(15) == 0);
        return mp;
    endfunction

    function automatic t_coef_set random_coefs();
        t_coef_set c;
        c.luma_gain  = t_coef'($urandom);
        c.u_to_blue  = t_coef'($urandom);
        c.u_to_green = t_coef'($urandom);
        c.v_to_green = t_coef'($urandom);
        c.v_to_red   = t_coef'($urandom);
        return c;
    endfunction

    // Sender gaps with noise on the payload, then one beat held until accepted.
    task automatic send_macropixel(input t_macropixel mp, input bit golden_en,
                                   input t_bgr_pair golden, input int idle_pct);
        t_macropixel noise;
        while ($urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            noise          = t_macropixel'($urandom);
            start          <= 1'b0;
            beat_golden_en <= 1'b0;
            i_y_first      <= noise.y_first;
            i_u_shared     <= noise.u_shared;
            i_y_second     <= noise.y_second;
            i_v_shared     <= noise.v_shared;
            i_last_in      <= noise.last;
        end
        @(negedge i_clk);
        start          <= 1'b1;
        beat_golden_en <= golden_en;
        beat_golden    <= golden;
        i_y_first      <= mp.y_first;
        i_u_shared     <= mp.u_shared;
        i_y_second     <= mp.y_second;
        i_v_shared     <= mp.v_shared;
        i_last_in      <= mp.last;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
    endtask

    // Drop start, wait for every expected beat, then let the pipe settle.
    task automatic wait_drained();
        int guard;
        guard = 0;
        @(negedge i_clk);
        start          <= 1'b0;
        beat_golden_en <= 1'b0;
        while (pending_bgr.size() != 0 && guard < DRAIN_GUARD) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (PIPE_LATENCY + 2) @(posedge i_clk);
    endtask

    // Writes the whole index space; indexes past the map get junk that must be ignored.
    task automatic program_coefs(input t_coef_set c);
        wait_drained();
        for (int idx = 0; idx <= CFG_IDX_LAST; idx++) begin
            @(negedge i_clk);
            i_cfg_we  <= 1'b1;
            i_cfg_idx <= CFG_IDX_W'(idx);
            case (t_cfg_idx'(idx))
                CFG_LUMA_GAIN:  i_cfg_data <= c.luma_gain;
                CFG_U_TO_BLUE:  i_cfg_data <= c.u_to_blue;
                CFG_U_TO_GREEN: i_cfg_data <= c.u_to_green;
                CFG_V_TO_GREEN: i_cfg_data <= c.v_to_green;
                CFG_V_TO_RED:   i_cfg_data <= c.v_to_red;
                default:        i_cfg_data <= COEF_W'($urandom);
            endcase
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        t_coef_set phase_coefs;
        t_bgr_pair no_golden;
        int        idle_pct;

        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_y_first      = '0;
        i_u_shared     = '0;
        i_y_second     = '0;
        i_v_shared     = '0;
        i_last_in      = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = '0;
        i_cfg_data     = '0;
        beat_golden_en = 1'b0;
        beat_golden    = '0;
        no_golden      = '0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table under reset coefficients. Black level and neutral chroma
        // give zero everywhere; all-max bytes overflow every channel; all-zero bytes
        // drive every sum negative.
        add_row( 16, 128,  16, 128, 1'b0, 1'b1,   0);
        add_row(255, 255, 255, 255, 1'b1, 1'b1, 255);
        add_row(  0,   0,   0,   0, 1'b0, 1'b1,   0);
        add_row(235, 128, 235, 128, 1'b0, 1'b0,   0);
        add_row(255,   0,   0, 255, 1'b1, 1'b0,   0);
        add_row(  0, 255, 255,   0, 1'b0, 1'b0,   0);
        add_row(128, 128, 128, 128, 1'b0, 1'b0,   0);
        add_row( 16, 255, 235,   0, 1'b0, 1'b0,   0);
        add_row( 81,  90, 145, 240, 1'b0, 1'b0,   0);
        add_row( 41, 240,  41, 110, 1'b0, 1'b0,   0);
        add_row(145,  54, 145,  34, 1'b1, 1'b0,   0);
        add_row(255, 128,   0, 128, 1'b1, 1'b0,   0);
        add_row(  0, 255,  16, 255, 1'b0, 1'b0,   0);
        add_row(  1,   2, 254, 253, 1'b0, 1'b0,   0);
        add_row(170,  85,  85, 170, 1'b1, 1'b0,   0);
        add_row( 15, 127,  17, 129, 1'b0, 1'b0,   0);
        add_row(240,  16, 240, 240, 1'b0, 1'b0,   0);
        foreach (directed_rows[i]) begin
            send_macropixel(directed_rows[i].mp, directed_rows[i].golden_en,
                            directed_rows[i].golden, 34);
        end

        // Random phases: sender gaps 34%, then 50%, then back to back.
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0: phase_coefs = '{default: t_coef'(1023)};
                1: phase_coefs = '{default: t_coef'(-1024)};
                3: begin
                    phase_coefs = '{default: t_coef'(-1024)};
                    phase_coefs.luma_gain = t_coef'(1023);
                end
                4: phase_coefs = '{default: t_coef'(0)};
                6: begin
                    phase_coefs = '{default: t_coef'(1023)};
                    phase_coefs.luma_gain = t_coef'(-1024);
                end
                7: phase_coefs = reset_coefs();
                default: phase_coefs = random_coefs();
            endcase
            idle_pct = (phase < 3) ? 34 : (phase < 6) ? 50 : 0;
            program_coefs(phase_coefs);
            repeat (BEATS_PER_PHASE) begin
                send_macropixel(random_macropixel(), 1'b0, no_golden, idle_pct);
            end
        end

        wait_drained();
        if (pending_bgr.size() != 0) begin
            if (fail_count < MAX_REPORTED) begin
                $display("[%0t] %0d expected beats never arrived", $realtime,
                         pending_bgr.size());
            end
            fail_count += pending_bgr.size();
        end

        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/yuyv2rgb_pkg.sv
rtl/yuyv2rgb_cfg_regs.sv
rtl/yuyv2rgb_convert.sv
rtl/yuyv_to_rgb_converter_core.sv
tb/sv/tb.sv
